/* rtl/qrs_pkg.sv */
// Shared types, widths and helpers for the quadratic root solver.
// No dependencies; every other rtl file refers to this package by scoped names.
`default_nettype none

package qrs_pkg;

    // Number format of coefficients and roots
    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int TOL_W     = 16;

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W;          // product width
    localparam int DW   = 2 * W + 2;      // discriminant width
    localparam int QW   = W + 1;          // square root width, also the sqrt cell count
    localparam int RSW  = W + 2;          // sqrt partial remainder
    localparam int SW   = W + 3;          // signed numerator
    localparam int NMW  = W + 2;          // numerator magnitude
    localparam int NW   = NMW + F;        // dividend width, also the divider cell count
    localparam int DNW  = W + 1;          // divisor width
    localparam int REMW = DNW;            // divider partial remainder

    // Root count codes
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_INF  = 2'd3;

    // Which solution path an item takes
    typedef enum logic [2:0] {
        K_NONE,
        K_INF,
        K_LIN,
        K_ONE,
        K_TWO
    } t_kind;

    typedef struct packed {
        logic signed [W-1:0] coef_quad;
        logic signed [W-1:0] coef_lin;
        logic signed [W-1:0] coef_const;
    } t_req;

    typedef struct packed {
        logic [1:0]          root_count;
        logic signed [W-1:0] root_one;
        logic signed [W-1:0] root_two;
        logic                overflow;
    } t_rsp;

    // Front-end stage contents (filled progressively)
    typedef struct packed {
        logic [W-1:0]  ma;
        logic [W-1:0]  mb;
        logic [W-1:0]  mc;
        logic          an;
        logic          bn;
        logic          cn;
        logic          la;
        logic          lb;
        logic          lc;
        logic [PW-1:0] b2;
        logic [PW-1:0] p;
        logic [DW-1:0] d;
        logic          dneg;
    } t_fe;

    // Side data riding along the square root chain
    typedef struct packed {
        t_kind                kind;
        logic signed [SW-1:0] sb;
        logic [DNW-1:0]       den;
        logic                 dsign;
    } t_ctl;

    typedef struct packed {
        logic [DW-1:0]  d;
        logic [RSW-1:0] r;
        logic [QW-1:0]  q;
        t_ctl           ctl;
    } t_sq;

    typedef struct packed {
        t_kind                kind;
        logic signed [SW-1:0] num1;
        logic signed [SW-1:0] num2;
        logic [DNW-1:0]       den;
        logic                 dsign;
    } t_num;

    // Divider lane: dividend shifts out the top while quotient bits shift in
    typedef struct packed {
        logic [NW-1:0]   x;
        logic [REMW-1:0] rem;
        logic [DNW-1:0]  den;
    } t_div;

    typedef struct packed {
        t_kind kind;
        logic  neg1;
        logic  neg2;
    } t_side;

    typedef struct packed {
        logic signed [W-1:0] val;
        logic                ovf;
    } t_sat;

    localparam logic [NW-1:0] SAT_NEG = {{(NW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
    localparam logic [NW-1:0] SAT_POS = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};

    // Clamp a signed quotient magnitude to the word range
    function automatic t_sat sat_word(input logic neg, input logic [NW-1:0] q);
        t_sat res;
        res.ovf = 1'b0;
        if (neg) begin
            if (q > SAT_NEG) begin
                res.val = {1'b1, {(W-1){1'b0}}};
                res.ovf = 1'b1;
            end else begin
                res.val = ~q[W-1:0] + 1'b1;
            end
        end else begin
            if (q > SAT_POS) begin
                res.val = {1'b0, {(W-1){1'b1}}};
                res.ovf = 1'b1;
            end else begin
                res.val = q[W-1:0];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/quadratic_root_solver.sv */
// Top level of the quadratic root solver: front end, square root chain,
// two divider chains and the saturating output register. Depends on qrs_pkg,
// qrs_front, qrs_sqrt_cell and qrs_div_cell.
//
//  channel   | signals                              | direction
//  ----------+--------------------------------------+----------
//  request   | i_valid, o_ready, i_req (t_req)      | in
//  result    | o_valid, i_ready, o_rsp (t_rsp)      | out
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_data | in
//
// One request per cycle while the pipe is not held; each result passes through
// 5 front stages, 33 square root cells, 2 numerator stages, 50 divider cells
// and the output register.
// Reset clears all valid bits and sets the tolerance register r_tol to 1.
// When a result sits unaccepted in the output register the whole pipe holds.
`default_nettype none

module quadratic_root_solver (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  qrs_pkg::t_req              i_req,
    output logic                       o_valid,
    input  logic                       i_ready,
    output qrs_pkg::t_rsp              o_rsp,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [qrs_pkg::TOL_W-1:0]  i_cfg_data
);

    logic [qrs_pkg::TOL_W-1:0] r_tol;
    logic                      en;

    qrs_pkg::t_sq  w_sq   [0:qrs_pkg::QW];
    logic          w_sq_v [0:qrs_pkg::QW];

    logic          r_n1_v, r_n2_v;
    qrs_pkg::t_num r_n1, n_n1;
    qrs_pkg::t_div r_n2_d1, r_n2_d2, n_n2_d1, n_n2_d2;
    qrs_pkg::t_side r_n2_side, n_n2_side;

    qrs_pkg::t_div  w_d1 [0:qrs_pkg::NW];
    qrs_pkg::t_div  w_d2 [0:qrs_pkg::NW];
    qrs_pkg::t_side r_side   [0:qrs_pkg::NW-1];
    logic           r_side_v [0:qrs_pkg::NW-1];

    logic          r_out_v;
    qrs_pkg::t_rsp r_rsp, n_rsp;
    qrs_pkg::t_sat sat1, sat2;

    logic signed [qrs_pkg::SW-1:0] sx, m1, m2;
    qrs_pkg::t_side                last_side;

    // Whole pipe advances unless a result is stuck in the output register
    assign en          = !r_out_v || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    // Tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= qrs_pkg::TOL_W'(1);
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    qrs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_req   (i_req),
        .i_tol   (r_tol),
        .o_valid (w_sq_v[0]),
        .o_sq    (w_sq[0])
    );

    // Square root chain, one bit pair per cell
    for (genvar g = 0; g < qrs_pkg::QW; g++) begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_sq_v[g]),
            .i_sq    (w_sq[g]),
            .o_valid (w_sq_v[g+1]),
            .o_sq    (w_sq[g+1])
        );
    end

    // Numerators -b + s and -b - s (s only on the two-root path)
    assign sx = (w_sq[qrs_pkg::QW].ctl.kind == qrs_pkg::K_TWO)
                ? qrs_pkg::SW'(w_sq[qrs_pkg::QW].q) : '0;

    always_comb begin
        n_n1.kind  = w_sq[qrs_pkg::QW].ctl.kind;
        n_n1.num1  = w_sq[qrs_pkg::QW].ctl.sb + sx;
        n_n1.num2  = w_sq[qrs_pkg::QW].ctl.sb - sx;
        n_n1.den   = w_sq[qrs_pkg::QW].ctl.den;
        n_n1.dsign = w_sq[qrs_pkg::QW].ctl.dsign;
    end

    // Magnitudes and quotient signs, dividend scaled by the fraction bits
    assign m1 = r_n1.num1[qrs_pkg::SW-1] ? -r_n1.num1 : r_n1.num1;
    assign m2 = r_n1.num2[qrs_pkg::SW-1] ? -r_n1.num2 : r_n1.num2;

    always_comb begin
        n_n2_d1.x   = {m1[qrs_pkg::NMW-1:0], {qrs_pkg::F{1'b0}}};
        n_n2_d1.rem = '0;
        n_n2_d1.den = r_n1.den;
        n_n2_d2.x   = {m2[qrs_pkg::NMW-1:0], {qrs_pkg::F{1'b0}}};
        n_n2_d2.rem = '0;
        n_n2_d2.den = r_n1.den;
        n_n2_side.kind = r_n1.kind;
        n_n2_side.neg1 = r_n1.num1[qrs_pkg::SW-1] ^ r_n1.dsign;
        n_n2_side.neg2 = r_n1.num2[qrs_pkg::SW-1] ^ r_n1.dsign;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n1_v <= 1'b0;
            r_n2_v <= 1'b0;
        end else if (en) begin
            r_n1_v <= w_sq_v[qrs_pkg::QW];
            r_n2_v <= r_n1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n1      <= n_n1;
            r_n2_d1   <= n_n2_d1;
            r_n2_d2   <= n_n2_d2;
            r_n2_side <= n_n2_side;
        end
    end

    // Two divider chains side by side
    assign w_d1[0] = r_n2_d1;
    assign w_d2[0] = r_n2_d2;

    for (genvar g = 0; g < qrs_pkg::NW; g++) begin : g_div
        qrs_div_cell u_div1 (
            .i_clk (i_clk),
            .i_en  (en),
            .i_dv  (w_d1[g]),
            .o_dv  (w_d1[g+1])
        );
        qrs_div_cell u_div2 (
            .i_clk (i_clk),
            .i_en  (en),
            .i_dv  (w_d2[g]),
            .o_dv  (w_d2[g+1])
        );
    end

    // Path and sign bits kept in step with the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < qrs_pkg::NW; k++) begin
                r_side_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_side_v[0] <= r_n2_v;
            for (int k = 1; k < qrs_pkg::NW; k++) begin
                r_side_v[k] <= r_side_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r_n2_side;
            for (int k = 1; k < qrs_pkg::NW; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Saturate and assemble the result
    assign last_side = r_side[qrs_pkg::NW-1];
    assign sat1 = qrs_pkg::sat_word(last_side.neg1, w_d1[qrs_pkg::NW].x);
    assign sat2 = qrs_pkg::sat_word(last_side.neg2, w_d2[qrs_pkg::NW].x);

    always_comb begin
        n_rsp = '0;
        unique case (last_side.kind)
            qrs_pkg::K_INF: begin
                n_rsp.root_count = qrs_pkg::CNT_INF;
            end
            qrs_pkg::K_LIN, qrs_pkg::K_ONE: begin
                n_rsp.root_count = qrs_pkg::CNT_ONE;
                n_rsp.root_one   = sat1.val;
                n_rsp.overflow   = sat1.ovf;
            end
            qrs_pkg::K_TWO: begin
                n_rsp.root_count = qrs_pkg::CNT_TWO;
                n_rsp.root_one   = sat1.val;
                n_rsp.root_two   = sat2.val;
                n_rsp.overflow   = sat1.ovf | sat2.ovf;
            end
            default: begin
                n_rsp.root_count = qrs_pkg::CNT_NONE;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_side_v[qrs_pkg::NW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_out_v;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire

/* rtl/qrs_front.sv */
// Front end: input register, magnitudes, products, discriminant, path select.
// Depends on qrs_pkg.
`default_nettype none

module qrs_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  qrs_pkg::t_req              i_req,
    input  logic [qrs_pkg::TOL_W-1:0]  i_tol,
    output logic                       o_valid,
    output qrs_pkg::t_sq               o_sq
);

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    qrs_pkg::t_req r_req;
    qrs_pkg::t_fe  r_f2, r_f3, r_f4;
    qrs_pkg::t_fe  n_f2, n_f3, n_f4;
    qrs_pkg::t_sq  r_sq, n_sq;

    logic [qrs_pkg::W-1:0]        tol_w;
    logic [qrs_pkg::DW-1:0]       thr;
    logic [qrs_pkg::DW-1:0]       b2x, p4x;
    logic                         ac_neg;
    logic signed [qrs_pkg::SW-1:0] mbx, mcx;

    assign tol_w = {{(qrs_pkg::W-qrs_pkg::TOL_W){1'b0}}, i_tol};
    assign thr   = {{(qrs_pkg::DW-qrs_pkg::TOL_W-qrs_pkg::F){1'b0}}, i_tol,
                    {qrs_pkg::F{1'b0}}};

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_req <= i_req;
            r_f2  <= n_f2;
            r_f3  <= n_f3;
            r_f4  <= n_f4;
            r_sq  <= n_sq;
        end
    end

    // Magnitudes, signs and near-zero flags
    always_comb begin
        n_f2    = '0;
        n_f2.an = r_req.coef_quad[qrs_pkg::W-1];
        n_f2.bn = r_req.coef_lin[qrs_pkg::W-1];
        n_f2.cn = r_req.coef_const[qrs_pkg::W-1];
        n_f2.ma = n_f2.an ? (~unsigned'(r_req.coef_quad) + 1'b1) : unsigned'(r_req.coef_quad);
        n_f2.mb = n_f2.bn ? (~unsigned'(r_req.coef_lin) + 1'b1) : unsigned'(r_req.coef_lin);
        n_f2.mc = n_f2.cn ? (~unsigned'(r_req.coef_const) + 1'b1)
                          : unsigned'(r_req.coef_const);
        n_f2.la = n_f2.ma <= tol_w;
        n_f2.lb = n_f2.mb <= tol_w;
        n_f2.lc = n_f2.mc <= tol_w;
    end

    // b^2 and |a*c|
    always_comb begin
        n_f3    = r_f2;
        n_f3.b2 = r_f2.mb * r_f2.mb;
        n_f3.p  = r_f2.ma * r_f2.mc;
    end

    // Discriminant b^2 - 4ac, exact when not negative; a negative one gives zero and sets dneg
    assign b2x    = {2'b00, r_f3.b2};
    assign p4x    = {r_f3.p, 2'b00};
    assign ac_neg = (r_f3.an != r_f3.cn) && (r_f3.ma != '0) && (r_f3.mc != '0);

    always_comb begin
        n_f4      = r_f3;
        n_f4.dneg = 1'b0;
        if (ac_neg) begin
            n_f4.d = b2x + p4x;
        end else if (p4x <= b2x) begin
            n_f4.d = b2x - p4x;
        end else begin
            n_f4.d    = '0;
            n_f4.dneg = 1'b1;
        end
    end

    // Path select and the operands the later stages need
    assign mbx = qrs_pkg::SW'(r_f4.mb);
    assign mcx = qrs_pkg::SW'(r_f4.mc);

    always_comb begin
        n_sq           = '0;
        n_sq.d         = r_f4.d;
        n_sq.ctl.sb    = r_f4.bn ? mbx : -mbx;
        n_sq.ctl.den   = {r_f4.ma, 1'b0};
        n_sq.ctl.dsign = r_f4.an;
        if (r_f4.la) begin
            if (r_f4.lb) begin
                n_sq.ctl.kind = r_f4.lc ? qrs_pkg::K_INF : qrs_pkg::K_NONE;
            end else begin
                n_sq.ctl.kind  = qrs_pkg::K_LIN;
                n_sq.ctl.sb    = r_f4.cn ? mcx : -mcx;
                n_sq.ctl.den   = {1'b0, r_f4.mb};
                n_sq.ctl.dsign = r_f4.bn;
            end
        end else if (r_f4.dneg) begin
            n_sq.ctl.kind = qrs_pkg::K_NONE;
        end else if (r_f4.d <= thr) begin
            n_sq.ctl.kind = qrs_pkg::K_ONE;
        end else begin
            n_sq.ctl.kind = qrs_pkg::K_TWO;
        end
    end

    assign o_valid = r_v5;
    assign o_sq    = r_sq;

endmodule

`default_nettype wire

/* rtl/qrs_sqrt_cell.sv */
// One digit-pair step of the floor square root, registered.
// Depends on qrs_pkg.
`default_nettype none

module qrs_sqrt_cell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  qrs_pkg::t_sq i_sq,
    output logic         o_valid,
    output qrs_pkg::t_sq o_sq
);

    logic               r_valid;
    qrs_pkg::t_sq       r_sq, n_sq;
    logic [qrs_pkg::RSW+1:0] trial, test, diff;

    // Bring down the next bit pair and try subtracting 4q+1
    assign trial = {i_sq.r, i_sq.d[qrs_pkg::DW-1 -: 2]};
    assign test  = {1'b0, i_sq.q, 2'b01};
    assign diff  = trial - test;

    always_comb begin
        n_sq   = i_sq;
        n_sq.d = {i_sq.d[qrs_pkg::DW-3:0], 2'b00};
        if (trial >= test) begin
            n_sq.r = diff[qrs_pkg::RSW-1:0];
            n_sq.q = {i_sq.q[qrs_pkg::QW-2:0], 1'b1};
        end else begin
            n_sq.r = trial[qrs_pkg::RSW-1:0];
            n_sq.q = {i_sq.q[qrs_pkg::QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_valid = r_valid;
    assign o_sq    = r_sq;

endmodule

`default_nettype wire

/* rtl/qrs_div_cell.sv */
// One restoring-division step: one quotient bit per cell, registered.
// Depends on qrs_pkg.
`default_nettype none

module qrs_div_cell (
    input  logic          i_clk,
    input  logic          i_en,
    input  qrs_pkg::t_div i_dv,
    output qrs_pkg::t_div o_dv
);

    qrs_pkg::t_div             r_dv, n_dv;
    logic [qrs_pkg::REMW:0]    trial, dext, diff;
    logic                      ge;

    // Shift in the next dividend bit and compare with the divisor
    assign trial = {i_dv.rem, i_dv.x[qrs_pkg::NW-1]};
    assign dext  = {1'b0, i_dv.den};
    assign diff  = trial - dext;
    assign ge    = trial >= dext;

    always_comb begin
        n_dv     = i_dv;
        n_dv.rem = ge ? diff[qrs_pkg::REMW-1:0] : trial[qrs_pkg::REMW-1:0];
        n_dv.x   = {i_dv.x[qrs_pkg::NW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv <= n_dv;
        end
    end

    assign o_dv = r_dv;

endmodule

`default_nettype wire
